// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the kinematics core
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset
`define DK_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset
`define DK_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dk_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dk_pkg
// Types, constants and saturating fixed-point helpers of the kinematics core.
// ---------------------------------------------------------------------------
package dk_pkg;

  localparam int DW        = 32;           // internal value width
  localparam int FB        = 16;           // fraction bits
  localparam int QWD       = DW + FB;      // divider quotient width
  localparam int DIV_LANES = 18;           // nine F inverse, nine C inverse
  localparam int DIV_STG   = QWD;          // one quotient bit per stage

  typedef logic signed [DW-1:0] val_t;
  typedef val_t mat_t [3][3];

  localparam val_t VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam val_t VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam val_t ONE  = val_t'(64'd1 << FB);
  localparam logic [2*DW-1:0] LIM = (2*DW)'(1) << (DW-1);

  typedef enum logic [2:0] {
    TEN_F    = 3'd0,
    TEN_FINV = 3'd1,
    TEN_C    = 3'd2,
    TEN_CINV = 3'd3,
    TEN_E    = 3'd4
  } tensor_e;

  localparam logic [1:0] DIMS_2D = 2'd2;

  typedef struct packed {
    val_t grad_00; val_t grad_01; val_t grad_02;
    val_t grad_10; val_t grad_11; val_t grad_12;
    val_t grad_20; val_t grad_21; val_t grad_22;
  } dk_in_t;

  typedef struct packed {
    tensor_e    tensor;
    logic [1:0] row;
    val_t       col0;
    val_t       col1;
    val_t       col2;
    val_t       det_f;
    logic       singular;
    logic       last;
  } dk_out_t;

  typedef struct packed {
    logic [1:0] dims;
  } dk_cfg_t;

  // data that rides along with the divider
  typedef struct {
    mat_t f;
    mat_t c;
    mat_t e;
    val_t det_f;
    val_t det_c;
    logic two;
  } side_t;

  // one divider lane between stages
  typedef struct packed {
    logic [DW:0]    rem;
    logic [QWD-1:0] num;
    logic [QWD-1:0] q;
    logic [DW-1:0]  ud;
    logic           neg;
  } dlane_t;

  function automatic val_t sat_add(val_t a, val_t b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
    return s[DW-1:0];
  endfunction

  function automatic val_t sat_sub(val_t a, val_t b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
    return s[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] mag(val_t a);
    return a[DW-1] ? DW'(-a) : DW'(a);
  endfunction

  // magnitude plus sign to a saturated value
  function automatic val_t sat_pack(logic [2*DW-1:0] m, logic neg);
    if (m >= LIM) return neg ? VMIN : VMAX;
    return neg ? -val_t'(m[DW-1:0]) : val_t'(m[DW-1:0]);
  endfunction

  // product truncated toward zero, saturated
  function automatic val_t fx_mul(val_t a, val_t b);
    logic [2*DW-1:0] p;
    p = (2*DW)'(mag(a)) * (2*DW)'(mag(b));
    return sat_pack(p >> FB, a[DW-1] ^ b[DW-1]);
  endfunction

  // halve, truncating toward zero
  function automatic val_t half_tz(val_t a);
    val_t s;
    s = a + val_t'(a[DW-1]);
    return s >>> 1;
  endfunction

  // one restoring division step
  function automatic dlane_t div_step(dlane_t l);
    dlane_t     o;
    logic [DW:0] r;
    logic        qb;
    r  = {l.rem[DW-1:0], l.num[QWD-1]};
    qb = 1'b0;
    if (r >= {1'b0, l.ud}) begin
      r  = r - {1'b0, l.ud};
      qb = 1'b1;
    end
    o     = l;
    o.rem = r;
    o.num = l.num << 1;
    o.q   = {l.q[QWD-2:0], qb};
    return o;
  endfunction

endpackage

// ===== rtl/core/dk_stream_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dk_stream_if
// Valid/ready channel carrying one payload of type T.
// ---------------------------------------------------------------------------
interface dk_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/dk_detcof.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dk_detcof
// Three-stage determinant and inverse numerators of a 3x3 (or 2x2) matrix.
// ---------------------------------------------------------------------------
module dk_detcof (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic         two_i,
  input  dk_pkg::mat_t m_i,
  output dk_pkg::val_t det_o,
  output dk_pkg::mat_t num_o
);
  import dk_pkg::*;

  val_t pa_q [3][3];
  val_t pb_q [3][3];
  val_t dp_q [6];
  mat_t ma_q;
  logic two_a_q;

  val_t cof_q [3][3];
  val_t trip_q [6];
  val_t det2_q;
  mat_t n2_q;
  logic two_b_q;

  val_t det_q;
  mat_t num_q;

  // stage A: pair products
  always_ff @(posedge clk_i) begin
    int i1, i2, j1, j2;
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          i1 = (i + 1 >= 3) ? i - 2 : i + 1;
          i2 = (i + 2 >= 3) ? i - 1 : i + 2;
          j1 = (j + 1 >= 3) ? j - 2 : j + 1;
          j2 = (j + 2 >= 3) ? j - 1 : j + 2;
          pa_q[i][j] <= fx_mul(m_i[i1][j1], m_i[i2][j2]);
          pb_q[i][j] <= fx_mul(m_i[i1][j2], m_i[i2][j1]);
        end
      end
      dp_q[0] <= fx_mul(m_i[0][0], m_i[1][1]);
      dp_q[1] <= fx_mul(m_i[1][0], m_i[2][1]);
      dp_q[2] <= fx_mul(m_i[2][0], m_i[0][1]);
      dp_q[3] <= fx_mul(m_i[0][2], m_i[1][1]);
      dp_q[4] <= fx_mul(m_i[0][0], m_i[1][2]);
      dp_q[5] <= fx_mul(m_i[0][1], m_i[1][0]);
      ma_q    <= m_i;
      two_a_q <= two_i;
    end
  end

  // stage B: cofactors, triple products, 2-D terms
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          cof_q[i][j] <= sat_sub(pa_q[i][j], pb_q[i][j]);
          n2_q[i][j]  <= '0;
        end
      end
      trip_q[0] <= fx_mul(dp_q[0], ma_q[2][2]);
      trip_q[1] <= fx_mul(dp_q[1], ma_q[0][2]);
      trip_q[2] <= fx_mul(dp_q[2], ma_q[1][2]);
      trip_q[3] <= fx_mul(dp_q[3], ma_q[2][0]);
      trip_q[4] <= fx_mul(dp_q[4], ma_q[2][1]);
      trip_q[5] <= fx_mul(dp_q[5], ma_q[2][2]);
      det2_q     <= sat_sub(dp_q[0], dp_q[5]);
      n2_q[0][0] <= ma_q[1][1];
      n2_q[0][1] <= sat_sub('0, ma_q[0][1]);
      n2_q[1][0] <= sat_sub('0, ma_q[1][0]);
      n2_q[1][1] <= ma_q[0][0];
      two_b_q    <= two_a_q;
    end
  end

  // stage C: determinant sum, transpose of cofactors
  always_ff @(posedge clk_i) begin
    val_t r;
    if (en_i) begin
      r = sat_add(trip_q[0], trip_q[1]);
      r = sat_add(r, trip_q[2]);
      r = sat_sub(r, trip_q[3]);
      r = sat_sub(r, trip_q[4]);
      r = sat_sub(r, trip_q[5]);
      det_q <= two_b_q ? det2_q : r;
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          num_q[a][b] <= two_b_q ? n2_q[a][b] : cof_q[b][a];
        end
      end
    end
  end

  assign det_o = det_q;
  assign num_o = num_q;

endmodule

// ===== rtl/core/dk_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dk_div
// Pipelined restoring divider, one quotient bit per stage, all lanes in step.
// ---------------------------------------------------------------------------
module dk_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  dk_pkg::val_t  num_i [dk_pkg::DIV_LANES],
  input  dk_pkg::val_t  den_i [dk_pkg::DIV_LANES],
  input  dk_pkg::side_t side_i,
  output logic          valid_o,
  output dk_pkg::val_t  quo_o [dk_pkg::DIV_LANES],
  output dk_pkg::side_t side_o
);
  import dk_pkg::*;

  dlane_t            lane_q [DIV_STG][DIV_LANES];
  side_t             side_q [DIV_STG];
  logic [DIV_STG-1:0] vld_q;
  dlane_t            init_d [DIV_LANES];

  // set up magnitudes, dividend scaled by the fraction bits
  always_comb begin
    for (int l = 0; l < DIV_LANES; l++) begin
      init_d[l].rem = '0;
      init_d[l].num = {mag(num_i[l]), {FB{1'b0}}};
      init_d[l].q   = '0;
      init_d[l].ud  = mag(den_i[l]);
      init_d[l].neg = num_i[l][DW-1] ^ den_i[l][DW-1];
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIV_STG-2:0], valid_i};
    end
  end

  // quotient stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        lane_q[0][l] <= div_step(init_d[l]);
        for (int s = 1; s < DIV_STG; s++) begin
          lane_q[s][l] <= div_step(lane_q[s-1][l]);
        end
      end
      side_q[0] <= side_i;
      for (int s = 1; s < DIV_STG; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // signed, saturated quotients
  always_comb begin
    for (int l = 0; l < DIV_LANES; l++) begin
      quo_o[l] = sat_pack((2*DW)'(lane_q[DIV_STG-1][l].q), lane_q[DIV_STG-1][l].neg);
    end
  end

  assign valid_o = vld_q[DIV_STG-1];
  assign side_o  = side_q[DIV_STG-1];

endmodule

// ===== rtl/core/dk_ser.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dk_ser
// Holds the five tensors of one item and sends them out one row per transfer.
// ---------------------------------------------------------------------------
module dk_ser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  dk_pkg::mat_t    ten_i [5],
  input  dk_pkg::val_t    det_f_i,
  input  logic            sing_f_i,
  input  logic            sing_c_i,
  output logic            can_load_o,
  output logic            valid_o,
  input  logic            ready_i,
  output dk_pkg::dk_out_t data_o
);
  import dk_pkg::*;

  mat_t       buf_q [5];
  val_t       det_q;
  logic       sf_q, sc_q;
  logic       busy_q;
  tensor_e    ten_q;
  logic [1:0] row_q;
  logic       fire, last_row;

  assign fire       = busy_q && ready_i;
  assign last_row   = (ten_q == TEN_E) && (row_q == 2'd2);
  assign can_load_o = !busy_q || (fire && last_row);

  // row sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ten_q  <= TEN_F;
      row_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      ten_q  <= TEN_F;
      row_q  <= '0;
    end else if (fire) begin
      if (last_row) begin
        busy_q <= 1'b0;
      end else if (row_q == 2'd2) begin
        row_q <= '0;
        ten_q <= tensor_e'(ten_q + 3'd1);
      end else begin
        row_q <= row_q + 2'd1;
      end
    end
  end

  // item buffer
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= ten_i;
      det_q <= det_f_i;
      sf_q  <= sing_f_i;
      sc_q  <= sing_c_i;
    end
  end

  // row select
  always_comb begin
    data_o.tensor = ten_q;
    data_o.row    = row_q;
    data_o.col0   = buf_q[ten_q][row_q][0];
    data_o.col1   = buf_q[ten_q][row_q][1];
    data_o.col2   = buf_q[ten_q][row_q][2];
    data_o.det_f  = det_q;
    case (ten_q)
      TEN_FINV: data_o.singular = sf_q;
      TEN_CINV: data_o.singular = sc_q;
      default:  data_o.singular = 1'b0;
    endcase
    data_o.last = last_row;
  end

  assign valid_o = busy_q;

endmodule

// ===== rtl/core/deformation_kinematics_3x3.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deformation_kinematics_3x3
// Deformation gradient, its inverse, Cauchy-Green tensor and inverse, strain.
// ---------------------------------------------------------------------------
// Each accepted displacement gradient produces fifteen result rows (F, F inverse,
// C, C inverse, E, three rows each), one per output transfer, so the single result
// channel sets the sustained item rate. Three stages form F, C and E, three more
// form determinants and cofactors, and a 48-stage divider (one quotient bit per
// stage) produces both inverses. Inputs are taken every cycle while the pipeline
// has room; a waiting result stalls the whole pipeline, and nothing is lost.
// Write dims only while the block is idle; dims = 2 selects 2-D mode.
module deformation_kinematics_3x3 (
  input  logic        clk_i,
  input  logic        rst_ni,
  dk_stream_if.sink   cfg_if,
  dk_stream_if.sink   in_if,
  dk_stream_if.source out_if
);
  import dk_pkg::*;

  `include "assert_macros.svh"

  logic [1:0] dims_q;
  logic       en, load, can_load, dv_out;
  logic [5:0] v_q;

  mat_t h_d;
  mat_t h1_q, f1_q;
  logic two1_q;
  mat_t f2_q, h2_q;
  val_t cp_q [3][3][3];
  val_t ep_q [3][3][3];
  logic two2_q;
  mat_t f3_q, c3_q, e3_q;
  logic two3_q;
  side_t sd_q [3];

  val_t det_f, det_c;
  mat_t num_f, num_c;
  val_t dnum [DIV_LANES];
  val_t dden [DIV_LANES];
  side_t side_in, side_out;
  val_t quo [DIV_LANES];
  mat_t tens [5];
  logic sing_f, sing_c;

  // configuration register
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= 2'd3;
    end else if (cfg_if.valid) begin
      dims_q <= cfg_if.data.dims;
    end
  end

  // whole pipeline moves unless a finished item waits on the serializer
  assign en          = !dv_out || can_load;
  assign load        = dv_out && can_load;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[4:0], in_if.valid};
    end
  end

  // input gradient, row and column 2 cleared in 2-D mode
  always_comb begin
    logic two;
    two = (dims_q == DIMS_2D);
    h_d[0][0] = in_if.data.grad_00;
    h_d[0][1] = in_if.data.grad_01;
    h_d[0][2] = two ? '0 : in_if.data.grad_02;
    h_d[1][0] = in_if.data.grad_10;
    h_d[1][1] = in_if.data.grad_11;
    h_d[1][2] = two ? '0 : in_if.data.grad_12;
    h_d[2][0] = two ? '0 : in_if.data.grad_20;
    h_d[2][1] = two ? '0 : in_if.data.grad_21;
    h_d[2][2] = two ? '0 : in_if.data.grad_22;
  end

  // stage 1: F = I + H
  always_ff @(posedge clk_i) begin
    if (en) begin
      h1_q   <= h_d;
      two1_q <= (dims_q == DIMS_2D);
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          f1_q[a][b] <= sat_add(h_d[a][b], (a == b) ? ONE : '0);
        end
      end
    end
  end

  // stage 2: products for C and E
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          for (int k = 0; k < 3; k++) begin
            cp_q[a][b][k] <= fx_mul(f1_q[k][a], f1_q[k][b]);
            ep_q[a][b][k] <= fx_mul(h1_q[k][a], h1_q[k][b]);
          end
        end
      end
      f2_q   <= f1_q;
      h2_q   <= h1_q;
      two2_q <= two1_q;
    end
  end

  // stage 3: sums for C and E
  always_ff @(posedge clk_i) begin
    val_t cs, es;
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          cs = '0;
          es = sat_add(h2_q[a][b], h2_q[b][a]);
          for (int k = 0; k < 3; k++) begin
            cs = sat_add(cs, cp_q[a][b][k]);
            es = sat_add(es, ep_q[a][b][k]);
          end
          c3_q[a][b] <= cs;
          e3_q[a][b] <= half_tz(es);
        end
      end
      f3_q   <= f2_q;
      two3_q <= two2_q;
    end
  end

  // stages 4 to 6: determinants and cofactors of F and C
  dk_detcof u_detcof_f (
    .clk_i (clk_i),
    .en_i  (en),
    .two_i (two3_q),
    .m_i   (f3_q),
    .det_o (det_f),
    .num_o (num_f)
  );

  dk_detcof u_detcof_c (
    .clk_i (clk_i),
    .en_i  (en),
    .two_i (two3_q),
    .m_i   (c3_q),
    .det_o (det_c),
    .num_o (num_c)
  );

  // side data alongside the determinant stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0].f     <= f3_q;
      sd_q[0].c     <= c3_q;
      sd_q[0].e     <= e3_q;
      sd_q[0].det_f <= '0;
      sd_q[0].det_c <= '0;
      sd_q[0].two   <= two3_q;
      sd_q[1]       <= sd_q[0];
      sd_q[2]       <= sd_q[1];
    end
  end

  // divider lanes: F inverse first, then C inverse
  always_comb begin
    side_in       = sd_q[2];
    side_in.det_f = det_f;
    side_in.det_c = det_c;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        dnum[a*3+b]     = num_f[a][b];
        dden[a*3+b]     = det_f;
        dnum[9+a*3+b]   = num_c[a][b];
        dden[9+a*3+b]   = det_c;
      end
    end
  end

  dk_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[5]),
    .num_i   (dnum),
    .den_i   (dden),
    .side_i  (side_in),
    .valid_o (dv_out),
    .quo_o   (quo),
    .side_o  (side_out)
  );

  // 2-D padding and singular handling of both inverses
  always_comb begin
    logic pad;
    sing_f  = (side_out.det_f == '0);
    sing_c  = (side_out.det_c == '0);
    tens[0] = side_out.f;
    tens[2] = side_out.c;
    tens[4] = side_out.e;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        pad = side_out.two && (a == 2 || b == 2);
        if (pad) begin
          tens[1][a][b] = (a == 2 && b == 2) ? ONE : '0;
          tens[3][a][b] = (a == 2 && b == 2) ? ONE : '0;
        end else begin
          tens[1][a][b] = sing_f ? '0 : quo[a*3+b];
          tens[3][a][b] = sing_c ? '0 : quo[9+a*3+b];
        end
      end
    end
  end

  dk_ser u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .ten_i      (tens),
    .det_f_i    (side_out.det_f),
    .sing_f_i   (sing_f),
    .sing_c_i   (sing_c),
    .can_load_o (can_load),
    .valid_o    (out_if.valid),
    .ready_i    (out_if.ready),
    .data_o     (out_if.data)
  );

  // checks
  `DK_ASSERT_NOW(a_last_row, clk_i, rst_ni, out_if.valid && out_if.data.last, out_if.data.tensor == TEN_E && out_if.data.row == 2'd2, "last on wrong row")
  `DK_ASSERT_NOW(a_sing_inv, clk_i, rst_ni, out_if.valid && out_if.data.singular, out_if.data.tensor == TEN_FINV || out_if.data.tensor == TEN_CINV, "singular off inverse")
  `DK_ASSERT_NOW(a_stall_why, clk_i, rst_ni, !in_if.ready, dv_out, "stall without waiting item")
  `DK_ASSERT_NXT(a_load_row0, clk_i, rst_ni, load, out_if.valid && out_if.data.tensor == TEN_F && out_if.data.row == 2'd0, "load not at F row 0")

endmodule

// ===== dv/tb_deformation_kinematics_3x3.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_deformation_kinematics_3x3
// Self-checking bench for the deformation kinematics core: drives displacement
// gradients in bursts and predicts all fifteen rows (F, F inverse, C, C inverse,
// E) in saturating Q16.16, comparing every output transfer field by field.
// ---------------------------------------------------------------------------
module tb_deformation_kinematics_3x3;
  import dk_pkg::*;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam longint QONE = 64'sd65536;
  localparam int     CYCLE_LIMIT = 400000;

  typedef longint qmat_t [3][3];

  logic clk_i;
  logic rst_ni;

  dk_stream_if #(.T(dk_cfg_t)) cfg_ch ();
  dk_stream_if #(.T(dk_in_t))  grad_ch ();
  dk_stream_if #(.T(dk_out_t)) row_ch ();

  deformation_kinematics_3x3 dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_ch),
    .in_if  (grad_ch),
    .out_if (row_ch)
  );

  // bench state
  logic [1:0] dims_q;
  dk_out_t    rows_pending [$];
  int         mismatch_cnt;
  int         stray_cnt;
  int         grads_sent;
  int         rows_checked;
  int         singular_rows;
  int         cycle_cnt;
  int         hold_left;
  int         rx_mode;
  int         gap_max;

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // ------------------------------------------------------------ arithmetic
  function automatic longint q_sat(longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint q_pack(logic [63:0] m, bit neg);
    if (neg) return (m > 64'd2147483648) ? QMIN : -longint'(m);
    return (m > 64'd2147483647) ? QMAX : longint'(m);
  endfunction

  function automatic longint q_mul(longint a, longint b);
    logic [63:0] ua, ub, p;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p  = (ua * ub) >> 16;
    return q_pack(p, (a < 0) != (b < 0));
  endfunction

  function automatic longint q_div(longint n, longint d);
    logic [63:0] un, ud;
    if (d == 0) return 0;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    return q_pack((un << 16) / ud, (n < 0) != (d < 0));
  endfunction

  function automatic longint q_det(qmat_t m, bit two);
    longint r;
    if (two) return q_sat(q_mul(m[0][0], m[1][1]) - q_mul(m[0][1], m[1][0]));
    r = q_mul(q_mul(m[0][0], m[1][1]), m[2][2]);
    r = q_sat(r + q_mul(q_mul(m[1][0], m[2][1]), m[0][2]));
    r = q_sat(r + q_mul(q_mul(m[2][0], m[0][1]), m[1][2]));
    r = q_sat(r - q_mul(q_mul(m[0][2], m[1][1]), m[2][0]));
    r = q_sat(r - q_mul(q_mul(m[0][0], m[1][2]), m[2][1]));
    r = q_sat(r - q_mul(q_mul(m[0][1], m[1][0]), m[2][2]));
    return r;
  endfunction

  // cofactor inverse; zero entries when the determinant vanishes, but for the 2-D padding one at [2][2]
  function automatic void q_inverse(input qmat_t m, input longint det, input bit two,
                                    output qmat_t r);
    qmat_t cof;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) r[i][j] = 0;
    if (two) r[2][2] = QONE;
    if (det == 0) return;
    if (two) begin
      r[0][0] = q_div(m[1][1], det);
      r[1][1] = q_div(m[0][0], det);
      r[0][1] = q_div(q_sat(-m[0][1]), det);
      r[1][0] = q_div(q_sat(-m[1][0]), det);
      return;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        cof[i][j] = q_sat(q_mul(m[(i+1)%3][(j+1)%3], m[(i+2)%3][(j+2)%3]) -
                          q_mul(m[(i+1)%3][(j+2)%3], m[(i+2)%3][(j+1)%3]));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) r[i][j] = q_div(cof[j][i], det);
  endfunction

  // all fifteen rows of one gradient under the current dims
  task automatic predict_kinematics(input dk_in_t g);
    qmat_t  h, fm, fi, cm, ci, em;
    qmat_t  t [5];
    longint jd, cd, x;
    bit     two;
    int     n;
    dk_out_t o;
    two = (dims_q == DIMS_2D);
    n   = two ? 2 : 3;
    h[0][0] = g.grad_00; h[0][1] = g.grad_01; h[0][2] = g.grad_02;
    h[1][0] = g.grad_10; h[1][1] = g.grad_11; h[1][2] = g.grad_12;
    h[2][0] = g.grad_20; h[2][1] = g.grad_21; h[2][2] = g.grad_22;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) begin
        if (two && (a == 2 || b == 2)) h[a][b] = 0;
        fm[a][b] = q_sat(h[a][b] + ((a == b) ? QONE : 0));
      end
    jd = q_det(fm, two);
    q_inverse(fm, jd, two, fi);
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) begin
        x = 0;
        for (int k = 0; k < 3; k++) x = q_sat(x + q_mul(fm[k][a], fm[k][b]));
        cm[a][b] = x;
      end
    if (two) begin
      cm[0][2] = 0; cm[1][2] = 0; cm[2][0] = 0; cm[2][1] = 0; cm[2][2] = QONE;
    end
    cd = q_det(cm, two);
    q_inverse(cm, cd, two, ci);
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) begin
        x = 0;
        if (a < n && b < n) begin
          x = q_sat(h[a][b] + h[b][a]);
          for (int k = 0; k < n; k++) x = q_sat(x + q_mul(h[k][a], h[k][b]));
          x = x / 2;
        end
        em[a][b] = x;
      end
    t[0] = fm; t[1] = fi; t[2] = cm; t[3] = ci; t[4] = em;
    for (int k = 0; k < 5; k++)
      for (int r = 0; r < 3; r++) begin
        o.tensor   = tensor_e'(k);
        o.row      = 2'(r);
        o.col0     = val_t'(t[k][r][0]);
        o.col1     = val_t'(t[k][r][1]);
        o.col2     = val_t'(t[k][r][2]);
        o.det_f    = val_t'(jd);
        o.singular = (o.tensor == TEN_FINV) ? (jd == 0) :
                     (o.tensor == TEN_CINV) ? (cd == 0) : 1'b0;
        o.last     = (o.tensor == TEN_E) && (r == 2);
        rows_pending.push_back(o);
      end
  endtask

  // ------------------------------------------------------------ result side
  // receiver: long hold-off when requested, otherwise its own stall pattern
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      row_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: row_ch.ready <= 1'b1;
        1: row_ch.ready <= ($urandom_range(0, 99) < 65);
        default: row_ch.ready <= ((cycle_cnt % 11) > 3) && ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // compare each output transfer with the oldest expected row
  always @(posedge clk_i) begin
    dk_out_t want;
    if (rst_ni && row_ch.valid && row_ch.ready) begin
      if (rows_pending.size() == 0) begin
        stray_cnt++;
        $display("unexpected row: tensor %0d row %0d", row_ch.data.tensor, row_ch.data.row);
      end else begin
        want = rows_pending.pop_front();
        rows_checked++;
        if (row_ch.data.singular) singular_rows++;
        if (row_ch.data !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch @%0t exp t%0d r%0d %h %h %h j=%h s%b l%b got t%0d r%0d %h %h %h j=%h s%b l%b",
                     $realtime, want.tensor, want.row, want.col0, want.col1, want.col2,
                     want.det_f, want.singular, want.last,
                     row_ch.data.tensor, row_ch.data.row, row_ch.data.col0,
                     row_ch.data.col1, row_ch.data.col2, row_ch.data.det_f,
                     row_ch.data.singular, row_ch.data.last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows outstanding", cycle_cnt,
               rows_pending.size());
      $display("tb_deformation_kinematics_3x3: FAIL");
      $finish;
    end
  end

  // ------------------------------------------------------------ input side
  // one gradient transfer; valid stays high for a following item
  task automatic send_grad(input dk_in_t g);
    grad_ch.valid <= 1'b1;
    grad_ch.data  <= g;
    do @(posedge clk_i); while (!grad_ch.ready);
    predict_kinematics(g);
    grads_sent++;
  endtask

  task automatic idle_input(input int n);
    grad_ch.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // wait for the pipeline to drain, then write dims
  task automatic write_dims(input logic [1:0] d);
    grad_ch.valid <= 1'b0;
    while (rows_pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.data.dims <= d;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    dims_q = d;
  endtask

  function automatic val_t rand_entry(int kind);
    case (kind)
      0: return val_t'($urandom);
      1: return val_t'(int'($urandom_range(0, 262144)) - 131072);
      default: return val_t'(int'($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  function automatic dk_in_t rand_grad();
    dk_in_t g;
    int     kind;
    kind = ($urandom_range(0, 9) < 2) ? 0 : ($urandom_range(0, 1) ? 1 : 2);
    g = {rand_entry(kind), rand_entry(kind), rand_entry(kind),
         rand_entry(kind), rand_entry(kind), rand_entry(kind),
         rand_entry(kind), rand_entry(kind), rand_entry(kind)};
    // occasionally force a singular F by making two rows of F equal
    if ($urandom_range(0, 11) == 0) begin
      g.grad_10 = g.grad_00 + ONE;
      g.grad_11 = g.grad_01 - ONE;
      g.grad_12 = g.grad_02;
    end
    return g;
  endfunction

  function automatic dk_in_t diag_grad(val_t d, val_t off);
    return {d, off, off, off, d, off, off, off, d};
  endfunction

  // bursts with random gaps
  task automatic send_random(input int count);
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        gap   = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
        if (gap > 0) idle_input(gap);
      end
      send_grad(rand_grad());
      burst--;
    end
  endtask

  // ------------------------------------------------------------ tests
  task automatic test_directed_3d();
    rx_mode = 0;
    send_grad(diag_grad(val_t'(0), val_t'(0)));        // identity
    send_grad(diag_grad(-ONE, val_t'(0)));             // F = 0, singular
    send_grad(diag_grad(VMAX, VMAX));                  // positive saturation
    send_grad(diag_grad(VMIN, VMIN));                  // negative saturation
    send_grad(diag_grad(VMAX, VMIN));
    send_grad(diag_grad(val_t'(32'h0000_8000), val_t'(32'h0000_4000)));
    send_grad(diag_grad(val_t'(-1), val_t'(1)));       // smallest steps
    send_grad({ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE});
    send_grad({val_t'(32'hFFFF_0000), ONE, val_t'(0), val_t'(0),
               val_t'(32'hFFFF_0000), ONE, ONE, val_t'(0), val_t'(32'hFFFF_0000)});
    send_grad({val_t'(32'h5555_5555), val_t'(32'hAAAA_AAAA), val_t'(32'h5555_5555),
               val_t'(32'hAAAA_AAAA), val_t'(32'h5555_5555), val_t'(32'hAAAA_AAAA),
               val_t'(32'h5555_5555), val_t'(32'hAAAA_AAAA), val_t'(32'h5555_5555)});
    send_grad(diag_grad(val_t'(32'h0000_0100), val_t'(0))); // tiny gradient, F just above identity
  endtask

  task automatic test_directed_2d();
    write_dims(DIMS_2D);
    rx_mode = 1;
    send_grad(diag_grad(val_t'(0), val_t'(0)));
    send_grad(diag_grad(-ONE, val_t'(0)));             // singular in the plane
    send_grad(diag_grad(VMAX, VMIN));
    send_grad({val_t'(32'h0001_8000), val_t'(32'h0000_8000), VMAX,
               val_t'(32'hFFFF_8000), val_t'(32'h0000_4000), VMIN,
               VMAX, VMIN, VMAX});                     // third row/column ignored
    send_grad(diag_grad(VMIN, VMAX));
  endtask

  task automatic test_random_2d();
    rx_mode = 2; gap_max = 5;
    send_random(50);
  endtask

  task automatic test_other_dims();
    // 0 and 1 both fall back to 3-D
    write_dims(2'd0);
    rx_mode = 1; gap_max = 3;
    send_random(15);
    write_dims(2'd1);
    send_random(15);
  endtask

  task automatic test_random_3d();
    write_dims(2'd3);
    rx_mode = 2; gap_max = 8;
    send_random(60);
    rx_mode = 0; gap_max = 0;
    send_random(25);
  endtask

  // receiver holds off while the sender keeps offering; more items than the
  // pipeline holds, so the input stalls
  task automatic test_backpressure();
    rx_mode = 1; gap_max = 0;
    hold_left <= 600;
    send_random(70);
  endtask

  // ------------------------------------------------------------ main
  initial begin
    rst_ni        = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    grad_ch.valid = 1'b0;
    grad_ch.data  = '0;
    row_ch.ready  = 1'b0;
    dims_q        = 2'd3;
    mismatch_cnt  = 0;
    stray_cnt     = 0;
    grads_sent    = 0;
    rows_checked  = 0;
    singular_rows = 0;
    cycle_cnt     = 0;
    hold_left     = 0;
    rx_mode       = 0;
    gap_max       = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed_3d();
    test_directed_2d();
    test_random_2d();
    test_other_dims();
    test_random_3d();
    test_backpressure();

    grad_ch.valid <= 1'b0;
    while (rows_pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("covered %0d gradients in 2-D and 3-D (dims 0..3), %0d rows checked",
             grads_sent, rows_checked);
    $display("%0d singular rows, %0d mismatches, %0d unexpected rows",
             singular_rows, mismatch_cnt, stray_cnt);
    if (mismatch_cnt == 0 && stray_cnt == 0 && rows_pending.size() == 0) begin
      $display("tb_deformation_kinematics_3x3: PASS");
    end else begin
      $display("tb_deformation_kinematics_3x3: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dk_pkg.sv
rtl/core/dk_stream_if.sv
rtl/core/dk_detcof.sv
rtl/core/dk_div.sv
rtl/core/dk_ser.sv
rtl/core/deformation_kinematics_3x3.sv
dv/tb_deformation_kinematics_3x3.sv
